FILE: src/column_mean_stddev_macros.svh
// Assertion macros for the column mean and standard deviation block.
// Used by column_mean_stddev.sv; no other dependencies.
`ifndef COLUMN_MEAN_STDDEV_MACROS_SVH
`define COLUMN_MEAN_STDDEV_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("column_mean_stddev: assertion failed");

// Next-cycle implication, disabled during reset.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("column_mean_stddev: assertion failed");

`endif

FILE: src/cms_pkg.sv
// Build constants, derived widths and types of the column mean and standard deviation block.
// No dependencies; imported by column_mean_stddev.
`default_nettype none

package cms_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_SAMPLES  = 65536;
    localparam int FRAC_BITS    = 8;

    localparam int IN_SAMPLE_W  = 16;
    localparam int MEAN_W       = 24;
    localparam int SD_W         = 24;
    localparam int COUNT_W      = 17;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 72;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH + CNT_W - 2;
    localparam int U_W    = CNT_W + SQ_W;
    localparam int DV_W   = U_W + 2 * FRAC_BITS;
    localparam int Q_W    = 2 * SAMPLE_WIDTH - 1 + 2 * FRAC_BITS;
    localparam int RT_W   = (Q_W + 1) / 2;
    localparam int QE_W   = 2 * RT_W;
    localparam int ITER_W = $clog2(DV_W);

    localparam logic [SUM_W-1:0] SAMPLE_MASK = (SUM_W'(1) << SAMPLE_WIDTH) - SUM_W'(1);
    localparam logic [MEAN_W-1:0] MEAN_MAX   = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN   = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [DV_W-1:0]   MEAN_LIM   = DV_W'(1) << (MEAN_W - 1);
    localparam logic [31:0]       COUNT_MAX  = (32'd1 << COUNT_W) - 32'd1;

    typedef logic [U_W-1:0]  t_word;
    typedef logic [DV_W-1:0] t_dvd;

endpackage

`default_nettype wire

FILE: src/column_mean_stddev.sv
// Column mean and standard deviation: stream accumulator with a shared add/subtract sequencer.
// Depends on cms_pkg and column_mean_stddev_macros.svh.
//
// Slave channel: one signed sample per transaction in i_s_tdata, i_s_tlast on the
// final sample of a column. While accumulating, o_s_tready is high and one sample is
// taken every cycle. After the last sample, o_s_tready drops while one shared adder
// runs the post-processing in order: sum magnitude, mean division, mean fixup, two
// shift-add multiplies, difference, a third multiply, variance division, square root
// and result load; then the result is presented and o_s_tready rises again.
// Master channel: mean, standard deviation and sample count in o_m_tdata, the dropped
// sample flag in o_m_tuser. The result sits in an output register, so the next column
// is accumulated while a result waits; if the next column finishes before the receiver
// takes the earlier result, the block holds in its load step with o_s_tready low.
// Samples past MAX_SAMPLES are dropped and flagged. Reset clears the accumulators and
// the pending result.

`include "column_mean_stddev_macros.svh"
`default_nettype none

module column_mean_stddev import cms_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [15:0] sample
    input  wire logic                  i_s_tlast,   // last_sample
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [23:0] mean_fixed, [47:24] stddev_fixed,
                                                    // [64:48] sample_count, [71:65] zero
    output logic                       o_m_tuser    // [0] overflow
);

    localparam logic [3:0] ST_ACC  = 4'd0;
    localparam logic [3:0] ST_SMAG = 4'd1;
    localparam logic [3:0] ST_MDIV = 4'd2;
    localparam logic [3:0] ST_MFIX = 4'd3;
    localparam logic [3:0] ST_MULA = 4'd4;
    localparam logic [3:0] ST_MULB = 4'd5;
    localparam logic [3:0] ST_DIFF = 4'd6;
    localparam logic [3:0] ST_MULN = 4'd7;
    localparam logic [3:0] ST_VDIV = 4'd8;
    localparam logic [3:0] ST_SQRT = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DV_W - 1);
    localparam logic [ITER_W-1:0] MUL_LAST  = ITER_W'(MAG_W - 1);
    localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(RT_W - 1);

    logic [3:0]          r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SQ_W-1:0]     r_sumsq, n_sumsq;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_drop, n_drop;
    logic                r_o_valid, n_o_valid;

    logic [MAG_W-1:0]    r_smag, n_smag;
    logic                r_neg, n_neg;
    t_dvd                r_dvd, n_dvd;
    t_word               r_dvs, n_dvs;
    t_word               r_rem, n_rem;
    t_word               r_acc, n_acc;
    t_word               r_mcand, n_mcand;
    logic [MAG_W-1:0]    r_mplier, n_mplier;
    t_word               r_prod, n_prod;
    logic [MEAN_W-1:0]   r_mean, n_mean;
    logic [MEAN_W-1:0]   r_o_mean, n_o_mean;
    logic [SD_W-1:0]     r_o_sd, n_o_sd;
    logic [COUNT_W-1:0]  r_o_cnt, n_o_cnt;
    logic                r_o_ovf, n_o_ovf;

    logic                      w_s_fire;
    logic [SUM_W-1:0]          w_raw, w_sx, w_sxn;
    logic                      w_neg_s;
    logic [SAMPLE_WIDTH-1:0]   w_mag;
    logic [2*SAMPLE_WIDTH-1:0] w_sq;
    logic                      w_room;

    t_word               w_u_a, w_u_b;
    logic                w_u_inv, w_u_cin;
    logic [U_W:0]        w_u_res;
    t_word               w_u_sum;
    logic                w_u_carry;

    t_word               w_div_t;
    t_word               w_root_t;
    logic                w_rem_zero;
    logic                w_sat_pos, w_sat_neg;
    logic [31:0]         w_cnt32;

    assign o_s_tready = (r_state == ST_ACC);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_raw   = SUM_W'(i_s_tdata) & SAMPLE_MASK;
    assign w_neg_s = w_raw[SAMPLE_WIDTH-1];
    assign w_sx    = w_neg_s ? (w_raw | ~SAMPLE_MASK) : w_raw;
    assign w_sxn   = SUM_W'(0) - w_sx;
    assign w_mag   = w_neg_s ? w_sxn[SAMPLE_WIDTH-1:0] : w_sx[SAMPLE_WIDTH-1:0];
    assign w_sq    = w_mag * w_mag;
    assign w_room  = (r_cnt < CNT_W'(MAX_SAMPLES));

    assign w_div_t    = {r_rem[U_W-2:0], r_dvd[DV_W-1]};
    assign w_root_t   = {r_rem[U_W-3:0], r_dvd[QE_W-1 -: 2]};
    assign w_rem_zero = (r_rem == '0);
    assign w_sat_pos  = |r_dvd[DV_W-1:MEAN_W-1];
    assign w_sat_neg  = w_sat_pos && !((r_dvd == MEAN_LIM) && w_rem_zero);
    assign w_cnt32    = 32'(r_cnt);

    // shared add/subtract unit
    always_comb begin
        w_u_a   = '0;
        w_u_b   = '0;
        w_u_inv = 1'b0;
        w_u_cin = 1'b0;
        unique case (r_state)
            ST_SMAG: begin
                w_u_b   = {{(U_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                w_u_inv = r_sum[SUM_W-1];
                w_u_cin = r_sum[SUM_W-1];
            end
            ST_MDIV, ST_VDIV: begin
                w_u_a   = w_div_t;
                w_u_b   = r_dvs;
                w_u_inv = 1'b1;
                w_u_cin = 1'b1;
            end
            ST_MFIX: begin
                w_u_b   = r_dvd[U_W-1:0];
                w_u_inv = 1'b1;
                w_u_cin = w_rem_zero;
            end
            ST_MULA, ST_MULB, ST_MULN: begin
                w_u_a = {r_acc[U_W-2:0], 1'b0};
                w_u_b = r_mplier[MAG_W-1] ? r_mcand : '0;
            end
            ST_DIFF: begin
                w_u_a   = r_prod;
                w_u_b   = r_acc;
                w_u_inv = 1'b1;
                w_u_cin = 1'b1;
            end
            ST_SQRT: begin
                w_u_a   = w_root_t;
                w_u_b   = {r_acc[U_W-3:0], 2'b01};
                w_u_inv = 1'b1;
                w_u_cin = 1'b1;
            end
            default: begin
                w_u_a = '0;
            end
        endcase
    end

    assign w_u_res   = {1'b0, w_u_a} + {1'b0, (w_u_inv ? ~w_u_b : w_u_b)} + (U_W+1)'(w_u_cin);
    assign w_u_sum   = w_u_res[U_W-1:0];
    assign w_u_carry = w_u_res[U_W];

    always_comb begin
        n_state   = r_state;
        n_iter    = r_iter + ITER_W'(1);
        n_sum     = r_sum;
        n_sumsq   = r_sumsq;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_o_valid = r_o_valid && !i_m_tready;
        n_smag    = r_smag;
        n_neg     = r_neg;
        n_dvd     = r_dvd;
        n_dvs     = r_dvs;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_prod    = r_prod;
        n_mean    = r_mean;
        n_o_mean  = r_o_mean;
        n_o_sd    = r_o_sd;
        n_o_cnt   = r_o_cnt;
        n_o_ovf   = r_o_ovf;
        unique case (r_state)
            ST_ACC: begin
                if (w_s_fire) begin
                    if (w_room) begin
                        n_sum   = r_sum + w_sx;
                        n_sumsq = r_sumsq + SQ_W'(w_sq);
                        n_cnt   = r_cnt + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = ST_SMAG;
                    end
                end
            end
            ST_SMAG: begin
                n_smag  = w_u_sum[MAG_W-1:0];
                n_neg   = r_sum[SUM_W-1];
                n_dvd   = DV_W'(w_u_sum[MAG_W-1:0]) << FRAC_BITS;
                n_dvs   = U_W'(r_cnt);
                n_rem   = '0;
                n_iter  = '0;
                n_state = ST_MDIV;
            end
            ST_MDIV, ST_VDIV: begin
                n_rem = w_u_carry ? w_u_sum : w_div_t;
                n_dvd = {r_dvd[DV_W-2:0], w_u_carry};
                if (r_iter == DIV_LAST) begin
                    n_iter = '0;
                    if (r_state == ST_MDIV) begin
                        n_state = ST_MFIX;
                    end else begin
                        n_rem   = '0;
                        n_acc   = '0;
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_MFIX: begin
                if (!r_neg) begin
                    n_mean = w_sat_pos ? MEAN_MAX : r_dvd[MEAN_W-1:0];
                end else begin
                    n_mean = w_sat_neg ? MEAN_MIN : w_u_sum[MEAN_W-1:0];
                end
                n_acc    = '0;
                n_mcand  = U_W'(r_sumsq);
                n_mplier = MAG_W'(r_cnt);
                n_iter   = '0;
                n_state  = ST_MULA;
            end
            ST_MULA, ST_MULB, ST_MULN: begin
                n_acc    = w_u_sum;
                n_mplier = {r_mplier[MAG_W-2:0], 1'b0};
                if (r_iter == MUL_LAST) begin
                    n_iter = '0;
                    if (r_state == ST_MULA) begin
                        n_prod   = w_u_sum;
                        n_acc    = '0;
                        n_mcand  = U_W'(r_smag);
                        n_mplier = r_smag;
                        n_state  = ST_MULB;
                    end else if (r_state == ST_MULB) begin
                        n_state = ST_DIFF;
                    end else begin
                        n_dvs   = w_u_sum;
                        n_rem   = '0;
                        n_state = ST_VDIV;
                    end
                end
            end
            ST_DIFF: begin
                n_dvd    = (w_u_carry ? DV_W'(w_u_sum) : '0) << (2 * FRAC_BITS);
                n_acc    = '0;
                n_mcand  = U_W'(r_cnt);
                n_mplier = MAG_W'(r_cnt);
                n_iter   = '0;
                n_state  = ST_MULN;
            end
            ST_SQRT: begin
                n_rem = w_u_carry ? w_u_sum : w_root_t;
                n_acc = {r_acc[U_W-2:0], w_u_carry};
                n_dvd = {r_dvd[DV_W-3:0], 2'b00};
                if (r_iter == ROOT_LAST) begin
                    n_iter  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_iter = '0;
                if (!r_o_valid || i_m_tready) begin
                    n_o_mean  = r_mean;
                    n_o_sd    = (|r_acc[U_W-1:SD_W]) ? {SD_W{1'b1}} : r_acc[SD_W-1:0];
                    n_o_cnt   = (w_cnt32 > COUNT_MAX) ? {COUNT_W{1'b1}} : w_cnt32[COUNT_W-1:0];
                    n_o_ovf   = r_drop;
                    n_o_valid = 1'b1;
                    n_sum     = '0;
                    n_sumsq   = '0;
                    n_cnt     = '0;
                    n_drop    = 1'b0;
                    n_state   = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACC;
            r_iter    <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iter    <= n_iter;
            r_sum     <= n_sum;
            r_sumsq   <= n_sumsq;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smag   <= n_smag;
        r_neg    <= n_neg;
        r_dvd    <= n_dvd;
        r_dvs    <= n_dvs;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_mean   <= n_mean;
        r_o_mean <= n_o_mean;
        r_o_sd   <= n_o_sd;
        r_o_cnt  <= n_o_cnt;
        r_o_ovf  <= n_o_ovf;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-MEAN_W-SD_W-COUNT_W){1'b0}}, r_o_cnt, r_o_sd, r_o_mean};
    assign o_m_tuser  = r_o_ovf;

    `CMS_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, w_s_fire && i_s_tlast, !o_s_tready)
    `CMS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_SAMPLES))
    `CMS_ASSERT_NEXT(a_hold_pending, i_clk, i_rst_n,
        (r_state == ST_DONE) && r_o_valid && !i_m_tready, r_state == ST_DONE)
    `CMS_ASSERT_NOW(a_result_count, i_clk, i_rst_n, o_m_tvalid, r_o_cnt != '0)

endmodule

`default_nettype wire
